// ===== design/cmr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler package
// Shared constants, status codes, operation codes and request types.
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int POOL_SLOTS        = 32;
  localparam int MAX_PAYLOAD_BYTES = 256;
  localparam int SLOT_TIMEOUT      = 5;
  localparam int WORD_BYTES        = 8;
  localparam int MAX_RESULTS       = 33;
  localparam int SLOT_W            = $clog2(POOL_SLOTS);
  localparam int CNT_W             = $clog2(POOL_SLOTS + 1);
  // First part index whose word would end beyond the payload limit.
  localparam int INDEX_LIMIT       = MAX_PAYLOAD_BYTES / WORD_BYTES;

  localparam logic [2:0] ST_REJECT = 3'd0;
  localparam logic [2:0] ST_ADDR   = 3'd1;
  localparam logic [2:0] ST_STORED = 3'd2;
  localparam logic [2:0] ST_WORD   = 3'd3;
  localparam logic [2:0] ST_ERROR  = 3'd4;
  localparam logic [2:0] ST_TICK   = 3'd5;
  localparam logic [2:0] ST_EXPIRE = 3'd6;

  typedef enum logic [2:0] {
    OP_REJECT,
    OP_ADDR,
    OP_TICK,
    OP_ERROR,
    OP_STORE,
    OP_SINGLE,
    OP_EMPTY_TAIL,
    OP_MULTI
  } op_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [7:0]  src;
    logic [15:0] key;
    logic [7:0]  idx;
    logic [3:0]  cnt;
    logic        len_bad;
    logic [63:0] data;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] key;
    logic [7:0]  src;
    logic [63:0] data;
    logic [3:0]  bytes;
    logic        last;
  } result_t;

  // Keeps the lowest cnt bytes of a word.
  function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      if (4'(b) < cnt) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== design/cmr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ===== design/cmr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reassembler front end
// Classifies each incoming frame or tick and queues it for the back end.
// ----------------------------------------------------------------------------
module cmr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      own_addr,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            mode,
  input  logic            standard_id,
  input  logic            no_address_flag,
  input  logic [7:0]      sender_addr,
  input  logic [15:0]     msg_key,
  input  logic [7:0]      frame_index,
  input  logic            end_flag,
  input  logic [3:0]      byte_count,
  input  logic [63:0]     payload,
  output logic            q_valid,
  output cmr_pkg::entry_t q_data,
  input  logic            q_pop
);

  cmr_pkg::entry_t ent;
  cmr_pkg::entry_t fifo_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            push;
  logic [3:0]      cnt_clamped;

  // Classification of the incoming request.
  always_comb begin
    cnt_clamped = (byte_count > 4'(cmr_pkg::WORD_BYTES)) ? 4'(cmr_pkg::WORD_BYTES)
                                                         : byte_count;
    ent         = '0;
    ent.src     = sender_addr;
    ent.key     = msg_key;
    ent.idx     = frame_index;
    ent.data    = payload;
    ent.cnt     = end_flag ? cnt_clamped : byte_count;
    ent.len_bad = ((16'(frame_index) << 3) + 16'(cnt_clamped)
                   > 16'(cmr_pkg::MAX_PAYLOAD_BYTES))
               || (16'(frame_index) + 16'd1 > 16'(cmr_pkg::MAX_RESULTS));
    if (mode) begin
      ent.op = cmr_pkg::OP_TICK;
    end else if (standard_id || no_address_flag) begin
      ent.op = cmr_pkg::OP_REJECT;
    end else if (sender_addr == 8'd0 || sender_addr == own_addr) begin
      ent.op = cmr_pkg::OP_ADDR;
    end else if (!end_flag) begin
      ent.op = (byte_count == 4'(cmr_pkg::WORD_BYTES)) ? cmr_pkg::OP_STORE
                                                       : cmr_pkg::OP_ERROR;
    end else if (frame_index == 8'd0) begin
      ent.op = cmr_pkg::OP_SINGLE;
    end else if (cnt_clamped == 4'd0) begin
      ent.op = cmr_pkg::OP_EMPTY_TAIL;
    end else begin
      ent.op = cmr_pkg::OP_MULTI;
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  // Two-entry request queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        fifo_r[wr_ptr_r] <= ent;
        wr_ptr_r         <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== design/cmr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reassembler back end
// Owns the slot pool, carries out each request and drives the result register.
// ----------------------------------------------------------------------------
module cmr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  cmr_pkg::entry_t  q_data,
  output logic             q_pop,
  output logic             res_valid,
  output cmr_pkg::result_t res,
  input  logic             res_ready
);

  localparam int N = cmr_pkg::POOL_SLOTS;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCAN, S_CHECK, S_VERIFY, S_FAIL, S_RD, S_WORD, S_TAIL
  } state_t;

  state_t                      state_r;
  cmr_pkg::entry_t             cur_r;
  logic [N-1:0]                valid_r;
  logic [15:0]                 key_r   [N];
  logic [7:0]                  sidx_r  [N];
  logic [2:0]                  timer_r [N];
  logic [cmr_pkg::SLOT_W-1:0]  scan_r;
  logic [cmr_pkg::CNT_W-1:0]   count_r;
  logic                        bad_r;
  logic [7:0]                  part_r;
  logic                        res_valid_r;
  cmr_pkg::result_t            res_r;

  logic [N-1:0]                valid_nxt;
  logic                        res_valid_nxt;
  cmr_pkg::result_t            res_nxt;

  logic [N-1:0]                match;
  logic [N-1:0]                pmatch;
  logic [N-1:0]                valid_nd;
  logic [cmr_pkg::SLOT_W-1:0]  pslot;
  logic [cmr_pkg::SLOT_W-1:0]  free_slot;
  logic                        any_free;
  logic                        out_free;
  logic                        expired;
  logic [63:0]                 rd_data;
  logic                        ram_wr;
  logic                        last_part;

  // Per-slot key and part compares, first-part drop and free-slot search.
  always_comb begin
    pslot     = '0;
    free_slot = '0;
    any_free  = 1'b0;
    expired   = 1'b0;
    for (int i = 0; i < N; i++) begin
      match[i]    = valid_r[i] && (key_r[i] == cur_r.key);
      pmatch[i]   = match[i] && (sidx_r[i] == part_r);
      valid_nd[i] = valid_r[i] && !(match[i] && cur_r.idx == 8'd0);
      if (valid_r[i] && timer_r[i] == 3'd0) begin
        expired = 1'b1;
      end
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (pmatch[i]) begin
        pslot = cmr_pkg::SLOT_W'(i);
      end
      if (!valid_nd[i]) begin
        free_slot = cmr_pkg::SLOT_W'(i);
        any_free  = 1'b1;
      end
    end
  end

  assign out_free  = !res_valid_r || res_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign last_part = (part_r == cur_r.idx - 8'd1);
  assign ram_wr    = (state_r == S_EXEC) && (cur_r.op == cmr_pkg::OP_STORE)
                  && out_free && any_free;

  cmr_ram #(.WIDTH(64), .DEPTH(N)) u_data_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (free_slot),
    .wr_data (cur_r.data),
    .rd_en   (state_r == S_RD),
    .rd_addr (pslot),
    .rd_data (rd_data)
  );

  // Next pool valid bits and next result register.
  always_comb begin
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    unique case (state_r)
      S_EXEC: begin
        if (out_free) begin
          res_nxt       = '0;
          res_nxt.last  = 1'b1;
          res_valid_nxt = 1'b1;
          case (cur_r.op)
            cmr_pkg::OP_TICK: begin
              res_nxt.status = expired ? cmr_pkg::ST_EXPIRE : cmr_pkg::ST_TICK;
              for (int i = 0; i < N; i++) begin
                if (valid_r[i] && timer_r[i] == 3'd0) begin
                  valid_nxt[i] = 1'b0;
                end
              end
            end
            cmr_pkg::OP_REJECT: res_nxt.status = cmr_pkg::ST_REJECT;
            cmr_pkg::OP_ADDR:   res_nxt.status = cmr_pkg::ST_ADDR;
            cmr_pkg::OP_STORE: begin
              res_nxt.key = cur_r.key;
              res_nxt.src = cur_r.src;
              valid_nxt   = valid_nd;
              if (any_free) begin
                res_nxt.status       = cmr_pkg::ST_STORED;
                valid_nxt[free_slot] = 1'b1;
              end else begin
                res_nxt.status = cmr_pkg::ST_ERROR;
              end
            end
            cmr_pkg::OP_SINGLE: begin
              valid_nxt      = valid_r & ~match;
              res_nxt.status = cmr_pkg::ST_WORD;
              res_nxt.key    = cur_r.key;
              res_nxt.src    = cur_r.src;
              res_nxt.data   = cur_r.data & cmr_pkg::byte_mask(cur_r.cnt);
              res_nxt.bytes  = cur_r.cnt;
              // An empty single frame only drops its key.
              if (cur_r.cnt == 4'd0) begin
                res_valid_nxt = 1'b0;
              end
            end
            default: begin
              // Middle part that is not a full word, or empty tail that also drops the key.
              if (cur_r.op == cmr_pkg::OP_EMPTY_TAIL) begin
                valid_nxt = valid_r & ~match;
              end
              res_nxt.status = cmr_pkg::ST_ERROR;
              res_nxt.key    = cur_r.key;
              res_nxt.src    = cur_r.src;
            end
          endcase
        end
      end
      S_FAIL: begin
        if (out_free) begin
          valid_nxt      = valid_r & ~match;
          res_nxt        = '0;
          res_nxt.status = cmr_pkg::ST_ERROR;
          res_nxt.key    = cur_r.key;
          res_nxt.src    = cur_r.src;
          res_nxt.last   = 1'b1;
          res_valid_nxt  = 1'b1;
        end
      end
      S_WORD: begin
        if (out_free) begin
          res_nxt.status = cmr_pkg::ST_WORD;
          res_nxt.key    = cur_r.key;
          res_nxt.src    = cur_r.src;
          res_nxt.data   = rd_data;
          res_nxt.bytes  = 4'(cmr_pkg::WORD_BYTES);
          res_nxt.last   = 1'b0;
          res_valid_nxt  = 1'b1;
        end
      end
      S_TAIL: begin
        if (out_free) begin
          valid_nxt      = valid_r & ~match;
          res_nxt.status = cmr_pkg::ST_WORD;
          res_nxt.key    = cur_r.key;
          res_nxt.src    = cur_r.src;
          res_nxt.data   = cur_r.data & cmr_pkg::byte_mask(cur_r.cnt);
          res_nxt.bytes  = cur_r.cnt;
          res_nxt.last   = 1'b1;
          res_valid_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, slot fields and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      res_valid_r <= res_valid_nxt;
      res_r       <= res_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_data;
            scan_r  <= '0;
            count_r <= '0;
            bad_r   <= q_data.len_bad;
            part_r  <= 8'd0;
            state_r <= (q_data.op == cmr_pkg::OP_MULTI) ? S_SCAN : S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (cur_r.op == cmr_pkg::OP_TICK) begin
              for (int i = 0; i < N; i++) begin
                if (valid_r[i] && timer_r[i] != 3'd0) begin
                  timer_r[i] <= timer_r[i] - 3'd1;
                end
              end
            end else if (cur_r.op == cmr_pkg::OP_STORE && any_free) begin
              key_r[free_slot]  <= cur_r.key;
              sidx_r[free_slot] <= cur_r.idx;
              for (int i = 0; i < N; i++) begin
                if ((valid_nd[i] && match[i]) || free_slot == cmr_pkg::SLOT_W'(i)) begin
                  timer_r[i] <= 3'(cmr_pkg::SLOT_TIMEOUT);
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (match[scan_r]) begin
            count_r <= count_r + cmr_pkg::CNT_W'(1);
            if (sidx_r[scan_r] >= cur_r.idx
                || 9'(sidx_r[scan_r]) >= 9'(cmr_pkg::INDEX_LIMIT)) begin
              bad_r <= 1'b1;
            end
          end
          scan_r <= scan_r + cmr_pkg::SLOT_W'(1);
          if (scan_r == cmr_pkg::SLOT_W'(N - 1)) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_r <= (bad_r || 9'(count_r) != 9'(cur_r.idx)) ? S_FAIL : S_VERIFY;
        end
        S_VERIFY: begin
          // Every part index below the count must be present exactly once.
          if (!(|pmatch)) begin
            state_r <= S_FAIL;
          end else if (last_part) begin
            part_r  <= 8'd0;
            state_r <= S_RD;
          end else begin
            part_r <= part_r + 8'd1;
          end
        end
        S_FAIL: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_RD: begin
          state_r <= S_WORD;
        end
        S_WORD: begin
          if (out_free) begin
            part_r  <= part_r + 8'd1;
            state_r <= last_part ? S_TAIL : S_RD;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/can_multiframe_reassembler_core.sv =====
`timescale 1ns / 1ps
// A single-result request passes the front queue, is picked up by the back end,
// is executed and has its result registered. A multipart final frame is picked
// up, then every pool slot is scanned in turn, the scan is checked, each part
// index is verified, each stored word is read from the registered RAM and sent,
// and the tail is sent last. The back end takes one request at a time; two more queue.
// Reset (synchronous, active low) empties the pool and sets the own address to 1.
// ----------------------------------------------------------------------------
// CAN multi-frame reassembler core
// Reassembles multi-frame CAN messages from a keyed pool of stored parts.
// ----------------------------------------------------------------------------
module can_multiframe_reassembler_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // standard_id, no_address_flag, src_address, msg_key, frame_index,
  // byte_count, payload, zero pad
  input  logic [103:0] in_tdata,
  input  logic         in_tuser,   // mode
  input  logic         in_tlast,   // end_flag
  output logic         out_tvalid,
  input  logic         out_tready,
  // packet_key, packet_source, word_data, word_bytes, zero pad
  output logic [95:0]  out_tdata,
  output logic [2:0]   out_tuser,  // status
  output logic         out_tlast   // last
);

  logic [7:0]       own_addr_r;
  logic             q_valid;
  logic             q_pop;
  cmr_pkg::entry_t  q_data;
  cmr_pkg::result_t res;

  // Own address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= 8'd1;
    end else if (cfg_wr_en) begin
      own_addr_r <= cfg_wr_data;
    end
  end

  cmr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .own_addr        (own_addr_r),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .mode            (in_tuser),
    .standard_id     (in_tdata[0]),
    .no_address_flag (in_tdata[1]),
    .sender_addr     (in_tdata[9:2]),
    .msg_key         (in_tdata[25:10]),
    .frame_index     (in_tdata[33:26]),
    .end_flag        (in_tlast),
    .byte_count      (in_tdata[37:34]),
    .payload         (in_tdata[101:38]),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop)
  );

  cmr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // Result packing.
  assign out_tdata = {4'd0, res.bytes, res.data, res.src, res.key};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule
